// ===== hdl/rvid_pkg.sv =====
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared types and constants for the RV64I instruction decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

    localparam int unsigned TABLE_LEN = 52;

    localparam logic [3:0] L_R    = 4'd0;
    localparam logic [3:0] L_I    = 4'd1;
    localparam logic [3:0] L_SH   = 4'd2;
    localparam logic [3:0] L_JR   = 4'd3;
    localparam logic [3:0] L_LD   = 4'd4;
    localparam logic [3:0] L_FN   = 4'd5;
    localparam logic [3:0] L_S    = 4'd6;
    localparam logic [3:0] L_B    = 4'd7;
    localparam logic [3:0] L_U    = 4'd8;
    localparam logic [3:0] L_J    = 4'd9;
    localparam logic [3:0] L_NONE = 4'd10;

    localparam logic [5:0] IX_BEQ   = 6'd4;
    localparam logic [5:0] IX_BNE   = 6'd5;
    localparam logic [5:0] IX_BLT   = 6'd6;
    localparam logic [5:0] IX_BGE   = 6'd7;
    localparam logic [5:0] IX_ADDI  = 6'd18;
    localparam logic [5:0] IX_SLTIU = 6'd20;
    localparam logic [5:0] IX_SLT   = 6'd27;
    localparam logic [5:0] IX_SLTU  = 6'd28;
    localparam logic [5:0] IX_ADDIW = 6'd43;

    localparam logic [4:0] PS_NONE  = 5'd0;
    localparam logic [4:0] PS_NOP   = 5'd1;
    localparam logic [4:0] PS_MV    = 5'd2;
    localparam logic [4:0] PS_SEXTW = 5'd3;
    localparam logic [4:0] PS_SEQZ  = 5'd4;
    localparam logic [4:0] PS_RET   = 5'd5;
    localparam logic [4:0] PS_JR    = 5'd6;
    localparam logic [4:0] PS_JALRA = 5'd7;
    localparam logic [4:0] PS_JALR0 = 5'd8;
    localparam logic [4:0] PS_J     = 5'd9;
    localparam logic [4:0] PS_JALR1 = 5'd10;
    localparam logic [4:0] PS_BLEZ  = 5'd11;
    localparam logic [4:0] PS_BZ    = 5'd12;
    localparam logic [4:0] PS_BGTZ  = 5'd13;
    localparam logic [4:0] PS_SNEZ  = 5'd14;
    localparam logic [4:0] PS_SLTZ  = 5'd15;
    localparam logic [4:0] PS_SGTZ  = 5'd16;

    typedef struct packed {
        logic [31:0] pat;
        logic [31:0] msk;
        logic [3:0]  lay;
    } t_entry;

    localparam logic [31:0] M_O   = 32'h0000007F;
    localparam logic [31:0] M_FO  = 32'h0000707F;
    localparam logic [31:0] M_7FO = 32'hFE00707F;
    localparam logic [31:0] M_6FO = 32'hFC00707F;
    localparam logic [31:0] M_ALL = 32'hFFFFFFFF;

    function automatic logic [31:0] fv(input logic [2:0] f3, input logic [6:0] op);
        return {17'd0, f3, 5'd0, op};
    endfunction

    function automatic t_entry table_entry(input logic [5:0] i);
        t_entry e;
        e = '{pat: 32'd0, msk: M_ALL, lay: L_NONE};
        unique case (i)
            6'd0:  e = '{fv(3'd0, 7'h37), M_O, L_U};
            6'd1:  e = '{fv(3'd0, 7'h17), M_O, L_U};
            6'd2:  e = '{fv(3'd0, 7'h6F), M_O, L_J};
            6'd3:  e = '{fv(3'd0, 7'h67), M_FO, L_JR};
            6'd4:  e = '{fv(3'd0, 7'h63), M_FO, L_B};
            6'd5:  e = '{fv(3'd1, 7'h63), M_FO, L_B};
            6'd6:  e = '{fv(3'd4, 7'h63), M_FO, L_B};
            6'd7:  e = '{fv(3'd5, 7'h63), M_FO, L_B};
            6'd8:  e = '{fv(3'd6, 7'h63), M_FO, L_B};
            6'd9:  e = '{fv(3'd7, 7'h63), M_FO, L_B};
            6'd10: e = '{fv(3'd0, 7'h03), M_FO, L_LD};
            6'd11: e = '{fv(3'd1, 7'h03), M_FO, L_LD};
            6'd12: e = '{fv(3'd2, 7'h03), M_FO, L_LD};
            6'd13: e = '{fv(3'd4, 7'h03), M_FO, L_LD};
            6'd14: e = '{fv(3'd5, 7'h03), M_FO, L_LD};
            6'd15: e = '{fv(3'd0, 7'h23), M_FO, L_S};
            6'd16: e = '{fv(3'd1, 7'h23), M_FO, L_S};
            6'd17: e = '{fv(3'd2, 7'h23), M_FO, L_S};
            6'd18: e = '{fv(3'd0, 7'h13), M_FO, L_I};
            6'd19: e = '{fv(3'd2, 7'h13), M_FO, L_I};
            6'd20: e = '{fv(3'd3, 7'h13), M_FO, L_I};
            6'd21: e = '{fv(3'd4, 7'h13), M_FO, L_I};
            6'd22: e = '{fv(3'd6, 7'h13), M_FO, L_I};
            6'd23: e = '{fv(3'd7, 7'h13), M_FO, L_I};
            6'd24: e = '{fv(3'd0, 7'h33), M_7FO, L_R};
            6'd25: e = '{32'h40000000 | fv(3'd0, 7'h33), M_7FO, L_R};
            6'd26: e = '{fv(3'd1, 7'h33), M_7FO, L_R};
            6'd27: e = '{fv(3'd2, 7'h33), M_7FO, L_R};
            6'd28: e = '{fv(3'd3, 7'h33), M_7FO, L_R};
            6'd29: e = '{fv(3'd4, 7'h33), M_7FO, L_R};
            6'd30: e = '{fv(3'd5, 7'h33), M_7FO, L_R};
            6'd31: e = '{32'h40000000 | fv(3'd5, 7'h33), M_7FO, L_R};
            6'd32: e = '{fv(3'd6, 7'h33), M_7FO, L_R};
            6'd33: e = '{fv(3'd7, 7'h33), M_7FO, L_R};
            6'd34: e = '{fv(3'd0, 7'h0F), M_FO, L_FN};
            6'd35: e = '{32'h00000073, M_ALL, L_NONE};
            6'd36: e = '{32'h00100073, M_ALL, L_NONE};
            6'd37: e = '{fv(3'd6, 7'h03), M_FO, L_LD};
            6'd38: e = '{fv(3'd3, 7'h03), M_FO, L_LD};
            6'd39: e = '{fv(3'd3, 7'h23), M_FO, L_S};
            6'd40: e = '{fv(3'd1, 7'h13), M_6FO, L_SH};
            6'd41: e = '{fv(3'd5, 7'h13), M_6FO, L_SH};
            6'd42: e = '{32'h40000000 | fv(3'd5, 7'h13), M_6FO, L_SH};
            6'd43: e = '{fv(3'd0, 7'h1B), M_FO, L_I};
            6'd44: e = '{fv(3'd1, 7'h1B), M_7FO, L_SH};
            6'd45: e = '{fv(3'd5, 7'h1B), M_7FO, L_SH};
            6'd46: e = '{32'h40000000 | fv(3'd5, 7'h1B), M_7FO, L_SH};
            6'd47: e = '{fv(3'd0, 7'h3B), M_7FO, L_R};
            6'd48: e = '{32'h40000000 | fv(3'd0, 7'h3B), M_7FO, L_R};
            6'd49: e = '{fv(3'd1, 7'h3B), M_7FO, L_R};
            6'd50: e = '{fv(3'd5, 7'h3B), M_7FO, L_R};
            6'd51: e = '{32'h40000000 | fv(3'd5, 7'h3B), M_7FO, L_R};
            default: e = '{32'd0, M_ALL, L_NONE};
        endcase
        return e;
    endfunction

    typedef struct packed {
        logic        vld;
        logic [31:0] insn;
        logic        pe;
    } t_s0;

    typedef struct packed {
        logic        vld;
        logic [31:0] insn;
        logic        pe;
        logic        hit;
        logic [5:0]  idx;
        logic [3:0]  lay;
    } t_s1;

    typedef struct packed {
        logic        vld;
        logic        hit;
        logic [5:0]  idx;
        logic [3:0]  lay;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [20:0] imm;
        logic        pe;
    } t_s2;

endpackage

// ===== hdl/rv64i_instruction_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder_unit
// RV64I decoder: table match, field extraction, pseudo selection.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// cmd      in         i_start & !o_busy    i_instruction
// result   out        o_done               o_known .. o_immediate
// cfg      in         i_cfg_we             i_cfg_wdata
// Four register stages: match, priority pick, fields, pseudo/output.
// One beat per cycle; o_busy never holds the flow.
// o_busy is held low; the receiver cannot stall, so nothing waits.
// Synchronous active-low reset clears valid bits and pseudo_enable.
// ----------------------------------------------------------------------------
module rv64i_instruction_decoder_unit
    import rvid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [31:0]        i_instruction,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_done,
    output logic               o_known,
    output logic [5:0]         o_mnemonic,
    output logic [3:0]         o_layout,
    output logic [4:0]         o_pseudo,
    output logic [4:0]         o_dest_reg,
    output logic [4:0]         o_src1_reg,
    output logic [4:0]         o_src2_reg,
    output logic signed [20:0] o_immediate
);

    logic r_pe;
    t_s0  s0;
    t_s1  s1;
    t_s2  s2;
    logic [4:0] n_ps;
    logic imm0;
    logic anyz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe <= 1'b0;
        end else if (i_cfg_we) begin
            r_pe <= i_cfg_wdata;
        end
    end

    assign o_busy  = 1'b0;
    assign s0.vld  = i_start;
    assign s0.insn = i_instruction;
    assign s0.pe   = r_pe;

    rvid_match u_match (.i_clk, .i_rst_n, .i_s0(s0), .o_s1(s1));
    rvid_fields u_fields (.i_clk, .i_rst_n, .i_s1(s1), .o_s2(s2));

    assign imm0 = s2.imm == 21'd0;
    assign anyz = s2.idx == IX_BEQ || s2.idx == IX_BNE || s2.idx == IX_BLT
               || s2.idx == IX_BGE;

    always_comb begin
        n_ps = PS_NONE;
        if (s2.pe) begin
            case (s2.lay)
                L_I: begin
                    if (s2.idx == IX_ADDI && s2.rd == 5'd0 && s2.rs1 == 5'd0 && imm0)
                        n_ps = PS_NOP;
                    else if (s2.idx == IX_ADDI && imm0) n_ps = PS_MV;
                    else if (s2.idx == IX_ADDIW && imm0) n_ps = PS_SEXTW;
                    else if (s2.idx == IX_SLTIU && s2.imm == 21'd1) n_ps = PS_SEQZ;
                end
                L_JR: begin
                    if (s2.rd == 5'd0 && imm0 && s2.rs1 == 5'd1) n_ps = PS_RET;
                    else if (s2.rd == 5'd0) n_ps = PS_JR;
                    else if (s2.rd == 5'd1) n_ps = PS_JALRA;
                    else if (imm0) n_ps = PS_JALR0;
                end
                L_J: begin
                    if (s2.rd == 5'd0) n_ps = PS_J;
                    else if (s2.rd == 5'd1) n_ps = PS_JALR1;
                end
                L_B: begin
                    if (s2.idx == IX_BGE && s2.rs1 == 5'd0) n_ps = PS_BLEZ;
                    else if (anyz && s2.rs2 == 5'd0) n_ps = PS_BZ;
                    else if (s2.idx == IX_BLT && s2.rs1 == 5'd0) n_ps = PS_BGTZ;
                end
                L_R: begin
                    if (s2.idx == IX_SLTU && s2.rs1 == 5'd0) n_ps = PS_SNEZ;
                    else if (s2.idx == IX_SLT && s2.rs2 == 5'd0) n_ps = PS_SLTZ;
                    else if (s2.idx == IX_SLT && s2.rs1 == 5'd0) n_ps = PS_SGTZ;
                end
                default: n_ps = PS_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= s2.vld;
        end
        o_known     <= s2.hit;
        o_mnemonic  <= s2.idx;
        o_layout    <= s2.lay;
        o_pseudo    <= n_ps;
        o_dest_reg  <= s2.rd;
        o_src1_reg  <= s2.rs1;
        o_src2_reg  <= s2.rs2;
        o_immediate <= s2.imm;
    end

endmodule

// ===== hdl/rvid_match.sv =====
// ----------------------------------------------------------------------------
// rvid_match
// Table match stage: first matching entry gives index and layout.
// ----------------------------------------------------------------------------
module rvid_match
    import rvid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s0  i_s0,
    output t_s1  o_s1
);

    logic [TABLE_LEN-1:0] hits;
    logic [TABLE_LEN-1:0] r_hits;
    logic [31:0]          r_insn;
    logic                 r_vld;
    logic                 r_pe;
    logic [5:0]           n_idx;
    logic [3:0]           n_lay;
    logic                 n_hit;
    t_entry               ent;
    t_entry               sel_ent;

    always_comb begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            ent     = table_entry(6'(i));
            hits[i] = (i_s0.insn & ent.msk) == ent.pat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_s0.vld;
        end
        r_hits <= hits;
        r_insn <= i_s0.insn;
        r_pe   <= i_s0.pe;
    end

    always_comb begin
        n_idx = '0;
        n_hit = 1'b0;
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (r_hits[i]) begin
                n_idx = 6'(i);
                n_hit = 1'b1;
            end
        end
        sel_ent = table_entry(n_idx);
        n_lay   = n_hit ? sel_ent.lay : L_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_s1.vld <= 1'b0;
        end else begin
            o_s1.vld <= r_vld;
        end
        o_s1.insn <= r_insn;
        o_s1.pe   <= r_pe;
        o_s1.hit  <= n_hit;
        o_s1.idx  <= n_idx;
        o_s1.lay  <= n_lay;
    end

endmodule

// ===== hdl/rvid_fields.sv =====
// ----------------------------------------------------------------------------
// rvid_fields
// Field stage: register slices and immediate per layout.
// ----------------------------------------------------------------------------
module rvid_fields
    import rvid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    logic [31:0] w;
    logic [20:0] n_imm;

    assign w = i_s1.insn;

    always_comb begin
        n_imm = '0;
        if (i_s1.hit) begin
            case (i_s1.lay)
                L_I, L_JR, L_LD: n_imm = {{9{w[31]}}, w[31:20]};
                L_SH:            n_imm = {15'd0, w[25:20]};
                L_S:             n_imm = {{9{w[31]}}, w[31:25], w[11:7]};
                L_B:             n_imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                L_U:             n_imm = {1'b0, w[31:12]};
                L_J:             n_imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                default:         n_imm = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_s2.vld <= 1'b0;
        end else begin
            o_s2.vld <= i_s1.vld;
        end
        o_s2.hit <= i_s1.hit;
        o_s2.idx <= i_s1.hit ? i_s1.idx : 6'd0;
        o_s2.lay <= i_s1.lay;
        o_s2.rd  <= i_s1.hit ? w[11:7] : 5'd0;
        o_s2.rs1 <= i_s1.hit ? w[19:15] : 5'd0;
        o_s2.rs2 <= i_s1.hit ? w[24:20] : 5'd0;
        o_s2.imm <= n_imm;
        o_s2.pe  <= i_s1.pe && i_s1.hit;
    end

endmodule
